[design/lise_pkg.sv]
// package for the longest increasing subsequence engine
// input and result word types shared by the top level; no dependencies
`default_nettype none

package lise_pkg;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               final_item;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] element;
        logic        [5:0]  length_here;
        logic        [5:0]  best_length;
        logic               dropped;
        logic               run_end;
    } t_out;

    // kind codes of a result word
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

endpackage

`default_nettype wire

[design/lise_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/longest_increasing_subsequence_engine_core.sv]
// top level of the longest increasing subsequence engine
// uses lise_pkg for word types and lise_ram for the tail, sample and pick stores
`default_nettype none

// Longest increasing subsequence engine. Each input word carries one signed
// 32-bit sample; the engine binary-searches the table of smallest tails by
// length, replaces that tail, stores the sample with its run length and
// returns one status word (run length here, best length so far, dropped
// flag). Samples beyond MAX_ITEMS are not stored and come back dropped. A
// word with final_item set is followed by the elements of one longest
// strictly increasing subsequence, in increasing order, after which the
// engine clears for a new sequence. One word is worked on at a time and
// o_in_stall stays high until the engine is back in idle. Each search
// step reads the tail ram and uses the single signed comparator
// (ceil(log2(longest+1)) steps, at most 6 for 32 entries); the search then
// ends, the write follows, the status word is handed out and the engine
// returns to idle. A dropped sample skips the search and the write. A
// final sample then scans the stored samples up to and including the first
// one of best length, walks back over the stored samples before that one,
// and reads each element from the pick ram. Output stalls hold the status
// and element words until they are taken.

module longest_increasing_subsequence_engine_core #(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire lise_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output lise_pkg::t_out       o_out_data
);

    import lise_pkg::*;

    // index into a store, a count up to MAX_ITEMS, a search bound up to MAX_ITEMS+1
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = $clog2(MAX_ITEMS + 2);
    localparam int STW = 32 + CW;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_SRCH = 11'b00000000010,
        S_CMP  = 11'b00000000100,
        S_WRT  = 11'b00000001000,
        S_STAT = 11'b00000010000,
        S_FRD  = 11'b00000100000,
        S_FCHK = 11'b00001000000,
        S_WRD  = 11'b00010000000,
        S_WCHK = 11'b00100000000,
        S_ERD  = 11'b01000000000,
        S_EOUT = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // current sample
    logic signed [31:0] r_sample, n_sample;
    logic               r_fin, n_fin;
    logic               r_drop, n_drop;
    logic [CW-1:0]      r_len, n_len;

    // binary search bounds
    logic [SW-1:0]      r_lo, n_lo;
    logic [SW-1:0]      r_hi, n_hi;
    logic [SW-1:0]      r_mid, n_mid;

    // sequence state
    logic [CW-1:0]      r_item_count, n_item_count;
    logic [CW-1:0]      r_longest, n_longest;

    // scan, walk back and emit
    logic [CW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_cur_val, n_cur_val;
    logic [CW-1:0]      r_cur_len, n_cur_len;
    logic [CW-1:0]      r_picked, n_picked;
    logic [CW-1:0]      r_emit_idx, n_emit_idx;

    // output register
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // ram ports
    logic               tail_we, tail_re;
    logic [IW-1:0]      tail_waddr, tail_raddr;
    logic [31:0]        tail_rdata;
    logic               store_we, store_re;
    logic [IW-1:0]      store_waddr, store_raddr;
    logic [STW-1:0]     store_wdata, store_rdata;
    logic               pick_we, pick_re;
    logic [IW-1:0]      pick_waddr, pick_raddr;
    logic [31:0]        pick_wdata, pick_rdata;

    // helpers
    logic               can_load;
    logic [SW:0]        mid_sum;
    logic [SW-1:0]      lo_clamped;
    logic [SW-1:0]      mid_less_one;
    logic [SW-1:0]      lo_less_one;
    logic [CW-1:0]      idx_less_one;
    logic [CW-1:0]      pick_pos;
    logic signed [31:0] s_val;
    logic [CW-1:0]      s_len;
    logic signed [31:0] cmp_a, cmp_b;
    logic               cmp_lt;
    logic               take_j;
    logic               emit_last;

    lise_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_tail (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (tail_waddr),
        .i_wdata (r_sample),
        .i_re    (tail_re),
        .i_raddr (tail_raddr),
        .o_rdata (tail_rdata)
    );

    // each stored sample with its run length in the low bits
    lise_ram #(.WIDTH(STW), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // chosen subsequence, last element first
    lise_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_pick (
        .i_clk   (i_clk),
        .i_we    (pick_we),
        .i_waddr (pick_waddr),
        .i_wdata (pick_wdata),
        .i_re    (pick_re),
        .i_raddr (pick_raddr),
        .o_rdata (pick_rdata)
    );

    assign can_load     = !r_out_valid || !i_out_stall;
    assign mid_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign lo_clamped   = (r_lo > SW'(MAX_ITEMS)) ? SW'(MAX_ITEMS) : r_lo;
    assign mid_less_one = mid_sum[SW:1] - SW'(1);
    assign lo_less_one  = lo_clamped - SW'(1);
    assign idx_less_one = r_idx - CW'(1);
    assign pick_pos     = r_picked - CW'(1) - r_emit_idx;
    assign s_val        = $signed(store_rdata[STW-1:CW]);
    assign s_len        = store_rdata[CW-1:0];
    // the shared signed comparator: tail against sample in the search,
    // stored sample against the last pick in the walk back
    assign cmp_a        = (r_state == S_CMP) ? $signed(tail_rdata) : s_val;
    assign cmp_b        = (r_state == S_CMP) ? r_sample : r_cur_val;
    assign cmp_lt       = cmp_a < cmp_b;
    // predecessor one length shorter and strictly smaller
    assign take_j       = (r_picked < CW'(MAX_ITEMS))
                       && ((CW + 1)'(r_cur_len) == (CW + 1)'(s_len) + (CW + 1)'(1))
                       && cmp_lt;
    assign emit_last    = (r_emit_idx + CW'(1)) == r_picked;

    always_comb begin
        n_state      = r_state;
        n_sample     = r_sample;
        n_fin        = r_fin;
        n_drop       = r_drop;
        n_len        = r_len;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_item_count = r_item_count;
        n_longest    = r_longest;
        n_idx        = r_idx;
        n_cur_val    = r_cur_val;
        n_cur_len    = r_cur_len;
        n_picked     = r_picked;
        n_emit_idx   = r_emit_idx;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        tail_we      = 1'b0;
        tail_re      = 1'b0;
        tail_waddr   = lo_less_one[IW-1:0];
        tail_raddr   = mid_less_one[IW-1:0];
        store_we     = 1'b0;
        store_re     = 1'b0;
        store_waddr  = r_item_count[IW-1:0];
        store_wdata  = {r_sample, CW'(lo_clamped)};
        store_raddr  = r_idx[IW-1:0];
        pick_we      = 1'b0;
        pick_re      = 1'b0;
        pick_waddr   = r_picked[IW-1:0];
        pick_wdata   = s_val;
        pick_raddr   = pick_pos[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_in_data.sample;
                    n_fin    = i_in_data.final_item;
                    n_lo     = SW'(1);
                    n_hi     = SW'(r_longest);
                    if (r_item_count < CW'(MAX_ITEMS)) begin
                        n_drop  = 1'b0;
                        n_state = S_SRCH;
                    end else begin
                        // capacity reached: state untouched
                        n_drop  = 1'b1;
                        n_len   = '0;
                        n_state = S_STAT;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo <= r_hi) begin
                    tail_re = 1'b1;
                    n_mid   = mid_sum[SW:1];
                    n_state = S_CMP;
                end else begin
                    n_state = S_WRT;
                end
            end
            S_CMP: begin
                if (cmp_lt) begin
                    n_lo = r_mid + SW'(1);
                end else begin
                    n_hi = r_mid - SW'(1);
                end
                n_state = S_SRCH;
            end
            S_WRT: begin
                tail_we      = 1'b1;
                store_we     = 1'b1;
                n_item_count = r_item_count + CW'(1);
                if (CW'(lo_clamped) > r_longest) begin
                    n_longest = CW'(lo_clamped);
                end
                n_len   = CW'(lo_clamped);
                n_state = S_STAT;
            end
            S_STAT: begin
                if (can_load) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_STATUS;
                    n_out.element     = '0;
                    n_out.length_here = 6'(r_len);
                    n_out.best_length = 6'(r_longest);
                    n_out.dropped     = r_drop;
                    n_out.run_end     = !r_fin || (r_longest == '0);
                    if (!r_fin) begin
                        n_state = S_IDLE;
                    end else if (r_longest == '0) begin
                        n_item_count = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                store_re = 1'b1;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                // first stored sample that reaches the best length
                if (s_len == r_longest) begin
                    pick_we    = 1'b1;
                    pick_waddr = '0;
                    n_picked   = CW'(1);
                    n_cur_val  = s_val;
                    n_cur_len  = s_len;
                    n_state    = S_WRD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_FRD;
                end
            end
            S_WRD: begin
                if (r_idx == '0) begin
                    n_emit_idx = '0;
                    n_state    = S_ERD;
                end else begin
                    store_re    = 1'b1;
                    store_raddr = idx_less_one[IW-1:0];
                    n_state     = S_WCHK;
                end
            end
            S_WCHK: begin
                if (take_j) begin
                    pick_we   = 1'b1;
                    n_picked  = r_picked + CW'(1);
                    n_cur_val = s_val;
                    n_cur_len = s_len;
                end
                n_idx   = idx_less_one;
                n_state = S_WRD;
            end
            S_ERD: begin
                pick_re = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (can_load) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_ELEMENT;
                    n_out.element     = $signed(pick_rdata);
                    n_out.length_here = 6'(r_emit_idx + CW'(1));
                    n_out.best_length = 6'(r_longest);
                    n_out.dropped     = 1'b0;
                    n_out.run_end     = emit_last;
                    if (emit_last) begin
                        n_item_count = '0;
                        n_longest    = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + CW'(1);
                        n_state    = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_item_count <= '0;
            r_longest    <= '0;
            r_picked     <= '0;
            r_emit_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_item_count <= n_item_count;
            r_longest    <= n_longest;
            r_picked     <= n_picked;
            r_emit_idx   <= n_emit_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_fin     <= n_fin;
        r_drop    <= n_drop;
        r_len     <= n_len;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_idx     <= n_idx;
        r_cur_val <= n_cur_val;
        r_cur_len <= n_cur_len;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_longest_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_longest <= r_item_count)
        else $error("best length exceeds stored sample count");

    a_count_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_count <= CW'(MAX_ITEMS))
        else $error("stored sample count exceeds capacity");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOUT) |-> (r_picked != '0) && (r_emit_idx < r_picked))
        else $error("element emit index outside picked range");

    a_picked_le_longest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERD || r_state == S_EOUT) |-> (r_picked <= r_longest))
        else $error("picked more elements than the best length");

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOUT && can_load && emit_last) |=>
            (r_item_count == '0) && (r_longest == '0))
        else $error("sequence not cleared after final element");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// testbench for longest_increasing_subsequence_engine_core: feeds sample words, predicts
// status and subsequence words in its own model and checks them in order; uses lise_pkg

module tb_top;
    import lise_pkg::*;

    localparam int MAX_ITEMS     = 32;
    localparam int TOTAL_WORDS   = 420;     // directed words plus about 400 random ones
    localparam int IDLE_PCT      = 15;
    localparam int CALM_FROM     = 120;     // accepted words between these: no idling at all
    localparam int CALM_TO       = 220;
    localparam int SETTLE_CYCLES = 200;     // longer than one full walk back and readout
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

    // how the values of one random sequence are drawn
    typedef enum int {
        SHAPE_SPREAD,   // full 32-bit range
        SHAPE_CLUSTER,  // tiny range, lots of equal values
        SHAPE_RISING,   // drifting upward, long runs
        SHAPE_FLIP      // single-bit neighbors mixed with fresh values
    } t_seq_shape;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_word   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_word;

    // sample words still to be sent, and result words the model says are on their way
    t_in  samples_pending[$];
    t_out lis_results_due[$];

    // model state: stored samples, their run lengths, smallest tail per length
    logic signed [31:0] seq_values [MAX_ITEMS];
    logic        [5:0]  seq_lengths[MAX_ITEMS];
    logic signed [31:0] min_tails  [MAX_ITEMS];
    logic signed [31:0] picks      [MAX_ITEMS];
    int stored_count = 0;
    int best_len     = 0;

    int   words_taken = 0;
    int   errors      = 0;
    int   cycles      = 0;
    logic in_taken    = 1'b0;

    always #4 clk = ~clk;

    longest_increasing_subsequence_engine_core #(
        .MAX_ITEMS(MAX_ITEMS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_word)
    );

    // advance the model by one accepted sample word and queue the result words it causes
    function automatic void lis_step(input t_in w);
        int   lo, hi, mid, run_len, n_picks, cur;
        logic drop;
        t_out r;
        run_len = 0;
        drop    = 1'b0;
        n_picks = 0;
        cur     = -1;

        if (stored_count < MAX_ITEMS) begin
            // smallest length whose tail is not below the sample, else one past the best
            lo = 1;
            hi = best_len;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if ($signed(min_tails[mid - 1]) < $signed(w.sample)) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            if (lo > MAX_ITEMS) begin
                lo = MAX_ITEMS;
            end
            min_tails[lo - 1]         = w.sample;
            seq_values[stored_count]  = w.sample;
            seq_lengths[stored_count] = 6'(lo);
            stored_count++;
            if (lo > best_len) begin
                best_len = lo;
            end
            run_len = lo;
        end else begin
            // table full: the sample is lost and the state stays as it was
            drop = 1'b1;
        end

        if (w.final_item) begin
            // first stored sample that ends a longest run, then walk back one length at a time
            for (int i = 0; i < stored_count; i++) begin
                if (seq_lengths[i] == best_len) begin
                    cur = i;
                    break;
                end
            end
            if (cur >= 0 && best_len > 0) begin
                picks[n_picks] = seq_values[cur];
                n_picks++;
                for (int j = cur - 1; j >= 0; j--) begin
                    if (n_picks < MAX_ITEMS && seq_lengths[cur] == seq_lengths[j] + 1 &&
                        $signed(seq_values[j]) < $signed(seq_values[cur])) begin
                        picks[n_picks] = seq_values[j];
                        n_picks++;
                        cur = j;
                    end
                end
            end
        end

        // status word first; it closes the burst unless elements follow
        r.kind        = KIND_STATUS;
        r.element     = '0;
        r.length_here = 6'(run_len);
        r.best_length = 6'(best_len);
        r.dropped     = drop;
        r.run_end     = !w.final_item || n_picks == 0;
        lis_results_due = {lis_results_due, r};

        // picks were gathered backward, so they go out from the top of the stack
        for (int k = 0; k < n_picks; k++) begin
            r.kind        = KIND_ELEMENT;
            r.element     = picks[n_picks - 1 - k];
            r.length_here = 6'(k + 1);
            r.best_length = 6'(best_len);
            r.dropped     = 1'b0;
            r.run_end     = (k == n_picks - 1);
            lis_results_due = {lis_results_due, r};
        end

        if (w.final_item) begin
            stored_count = 0;
            best_len     = 0;
        end
    endfunction

    task automatic push_sample(input logic signed [31:0] v, input logic fin);
        t_in w;
        w.sample     = v;
        w.final_item = fin;
        samples_pending = {samples_pending, w};
    endtask

    // monitor: checks result words and feeds accepted sample words to the model
    always @(posedge clk) begin
        t_out want;
        if (rst_n) begin
            // a result at this edge can't come from a word taken at the same edge,
            // so it is checked before the model moves on
            if (out_valid && !out_stall) begin
                if (lis_results_due.size() == 0) begin
                    $error("result word with nothing due: %p", out_word);
                    errors++;
                end else begin
                    want = lis_results_due.pop_front();
                    if (out_word.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, out_word.kind);
                        errors++;
                    end
                    if (out_word.element !== want.element) begin
                        $error("element: expected %0d, got %0d",
                               $signed(want.element), $signed(out_word.element));
                        errors++;
                    end
                    if (out_word.length_here !== want.length_here) begin
                        $error("length_here: expected %0d, got %0d",
                               want.length_here, out_word.length_here);
                        errors++;
                    end
                    if (out_word.best_length !== want.best_length) begin
                        $error("best_length: expected %0d, got %0d",
                               want.best_length, out_word.best_length);
                        errors++;
                    end
                    if (out_word.dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, out_word.dropped);
                        errors++;
                    end
                    if (out_word.run_end !== want.run_end) begin
                        $error("run_end: expected %0d, got %0d", want.run_end, out_word.run_end);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                lis_step(in_word);
                words_taken++;
            end
        end
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // driver: a new word goes out only once the last one was taken or the line was idle
    always @(negedge clk) begin
        logic calm;
        calm = words_taken >= CALM_FROM && words_taken < CALM_TO;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (samples_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_word  <= samples_pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver side: random stall, none during the calm stretch
    always @(negedge clk) begin
        out_stall <= rst_n && !(words_taken >= CALM_FROM && words_taken < CALM_TO) &&
                     ($urandom_range(99) < IDLE_PCT);
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int                 seq_len;
        t_seq_shape         shape;
        logic signed [31:0] v;
        int                 classic[8];
        classic = '{10, 9, 2, 5, 3, 7, 101, 18};

        // lone sample at either extreme: stored on the final word itself
        push_sample(MOST_NEG, 1'b1);
        push_sample(MOST_POS, 1'b1);
        // extremes rising, then falling
        push_sample(MOST_NEG, 1'b0);
        push_sample(MOST_POS, 1'b1);
        push_sample(MOST_POS, 1'b0);
        push_sample(MOST_NEG, 1'b1);
        // equal values never extend one another
        push_sample(32'sd5, 1'b0);
        push_sample(32'sd5, 1'b0);
        push_sample(32'sd5, 1'b1);
        // textbook mix with replaced tails and a walk back that skips samples
        foreach (classic[k]) begin
            push_sample(32'(classic[k]), k == 7);
        end
        // run across the sign boundary
        for (int k = -1; k <= 2; k++) begin
            push_sample(32'(k), k == 2);
        end

        // random sequences, mostly short; about one in eight overflows the table,
        // which also drops its final word
        while (samples_pending.size() < TOTAL_WORDS) begin
            seq_len = ($urandom_range(7) == 0) ? $urandom_range(40, MAX_ITEMS + 1)
                                                : $urandom_range(12, 1);
            shape = t_seq_shape'($urandom_range(3));
            v = $urandom;
            for (int k = 0; k < seq_len; k++) begin
                case (shape)
                    SHAPE_SPREAD: begin
                        v = $urandom;
                    end
                    SHAPE_CLUSTER: begin
                        v = $signed($urandom_range(15)) - 8;
                    end
                    SHAPE_RISING: begin
                        v = v + $signed($urandom_range(24)) - 8;
                    end
                    default: begin
                        v = ($urandom_range(1) == 0) ? $urandom : v ^ (32'h1 << $urandom_range(31));
                    end
                endcase
                push_sample(v, k == seq_len - 1);
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: everything sent, nothing still due
        while (samples_pending.size() != 0 || in_valid || lis_results_due.size() != 0) begin
            @(negedge clk);
        end
        // room for any stray word the engine might still put out
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
